@@ rtl/core/dogx_pkg.sv @@
package dogx_pkg;

   // Field and register widths
   localparam int SAMPLE_W      = 32;
   localparam int THRESHOLD_W   = 31;
   localparam int ROW_LENGTH_W  = 11;
   localparam int SCALE_COUNT_W = 7;
   localparam int SCALE_INDEX_W = 6;
   localparam int TIME_INDEX_W  = 10;

   // Register file
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_LENGTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_COUNT = 2'd2;

   localparam logic [THRESHOLD_W-1:0]   THRESHOLD_RST   = '0;
   localparam logic [ROW_LENGTH_W-1:0]  ROW_LENGTH_RST  = 11'd1024;
   localparam logic [SCALE_COUNT_W-1:0] SCALE_COUNT_RST = 7'd64;

   // Default sizing
   localparam int DEF_MAX_LEN    = 1024;
   localparam int DEF_MAX_SCALES = 64;

   // Output queue
   localparam int MAX_RESULTS = 2;
   localparam int OUT_DEPTH   = 8;
   localparam int OUT_PTR_W   = 3;
   localparam int OUT_CNT_W   = 4;
   localparam int CREDIT_W    = 5;

   // Window refill sequencer
   typedef enum logic [2:0] {
      FILL_IDLE,
      FILL_RD0,
      FILL_RD1,
      FILL_RD2,
      FILL_CAP
   } dogx_fill_type;

   // Control carried with a word into the compare stage
   typedef struct packed {
      logic valid;
      logic has_l1;
      logic has_l2;
      logic judge_prev;
      logic judge_last;
   } dogx_s1_type;

   typedef struct packed {
      logic [SCALE_INDEX_W-1:0] scale_index;
      logic [TIME_INDEX_W-1:0]  time_index;
      logic                     is_maximum;
   } dogx_result_type;

   // Up to two results from one input word, slot 0 first
   typedef struct packed {
      logic            v0;
      dogx_result_type r0;
      logic            v1;
      dogx_result_type r1;
   } dogx_pair_type;

   typedef struct packed {
      dogx_result_type res;
      logic            last_of_run;
   } dogx_entry_type;

endpackage

@@ rtl/core/dogx_line_store.sv @@
module dogx_line_store
   import dogx_pkg::*;
#(
   parameter int DEPTH  = 3 * DEF_MAX_LEN,
   parameter int ADDR_W = $clog2(3 * DEF_MAX_LEN)
)(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [SAMPLE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]   rd_addr_a,
   input  logic [ADDR_W-1:0]   rd_addr_b,
   output logic [SAMPLE_W-1:0] rd_data_a,
   output logic [SAMPLE_W-1:0] rd_data_b
);

   logic [SAMPLE_W-1:0] row_mem_ff [DEPTH];
   logic [SAMPLE_W-1:0] rd_a_ff;
   logic [SAMPLE_W-1:0] rd_b_ff;

   // One write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= row_mem_ff[rd_addr_a];
      rd_b_ff <= row_mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ rtl/core/dogx_judge.sv @@
module dogx_judge
   import dogx_pkg::*;
#(
   parameter int COL_W = $clog2(DEF_MAX_LEN),
   parameter int ROW_W = $clog2(DEF_MAX_SCALES)
)(
   input  logic                       clock,
   input  logic                       reset,
   input  logic [THRESHOLD_W-1:0]     threshold,
   input  dogx_s1_type                s1,
   input  logic [COL_W-1:0]           s1_col,
   input  logic [ROW_W-1:0]           s1_row,
   input  logic signed [SAMPLE_W-1:0] s1_sample,
   input  logic [SAMPLE_W-1:0]        rd_data_a,
   input  logic [SAMPLE_W-1:0]        rd_data_b,
   input  dogx_fill_type              fill_state,
   output dogx_pair_type              pair
);

   // Window of the two previous columns: old, middle and current line
   logic signed [SAMPLE_W-1:0] w1_old_ff, w1_mid_ff, w1_cur_ff;
   logic signed [SAMPLE_W-1:0] w2_old_ff, w2_mid_ff, w2_cur_ff;
   logic signed [SAMPLE_W-1:0] new_old, new_mid, new_cur;
   logic signed [SAMPLE_W-1:0] thr_pos, thr_neg;

   logic above0, below0, big0;
   logic above1, below1, big1;
   logic            valid0_in, valid1_in, valid0_ff, valid1_ff;
   dogx_result_type res0_in, res1_in, res0_ff, res1_ff;

   // Port A carries the middle line, port B the old line, outside refill
   assign new_mid = $signed(rd_data_a);
   assign new_old = $signed(rd_data_b);
   assign new_cur = s1_sample;
   assign thr_pos = $signed({1'b0, threshold});
   assign thr_neg = -thr_pos;

   // Window shift on a word, direct loads during refill
   always_ff @(posedge clock) begin
      if (s1.valid) begin
         w2_old_ff <= w1_old_ff;
         w2_mid_ff <= w1_mid_ff;
         w2_cur_ff <= w1_cur_ff;
         w1_old_ff <= new_old;
         w1_mid_ff <= new_mid;
         w1_cur_ff <= new_cur;
      end else begin
         case (fill_state)
            FILL_RD1: begin
               w1_mid_ff <= new_mid;
               w1_old_ff <= $signed(rd_data_b);
            end
            FILL_RD2: begin
               w1_cur_ff <= $signed(rd_data_a);
               w2_old_ff <= $signed(rd_data_b);
            end
            FILL_CAP: begin
               w2_mid_ff <= $signed(rd_data_a);
               w2_cur_ff <= $signed(rd_data_b);
            end
            default: ;
         endcase
      end
   end

   // Column c-1: center is the middle line one column back
   always_comb begin
      above0 = (w1_mid_ff > w1_old_ff) && (w1_mid_ff > new_old) &&
               (w1_mid_ff > w1_cur_ff) && (w1_mid_ff > new_cur) &&
               (w1_mid_ff > new_mid) &&
               (!s1.has_l2 || ((w1_mid_ff > w2_old_ff) && (w1_mid_ff > w2_mid_ff) &&
                               (w1_mid_ff > w2_cur_ff)));
      below0 = (w1_mid_ff < w1_old_ff) && (w1_mid_ff < new_old) &&
               (w1_mid_ff < w1_cur_ff) && (w1_mid_ff < new_cur) &&
               (w1_mid_ff < new_mid) &&
               (!s1.has_l2 || ((w1_mid_ff < w2_old_ff) && (w1_mid_ff < w2_mid_ff) &&
                               (w1_mid_ff < w2_cur_ff)));
      big0   = (w1_mid_ff > thr_pos) || (w1_mid_ff < thr_neg);
   end

   // Column c at row end: right side clipped
   always_comb begin
      above1 = (new_mid > new_old) && (new_mid > new_cur) &&
               (!s1.has_l1 || ((new_mid > w1_old_ff) && (new_mid > w1_mid_ff) &&
                               (new_mid > w1_cur_ff)));
      below1 = (new_mid < new_old) && (new_mid < new_cur) &&
               (!s1.has_l1 || ((new_mid < w1_old_ff) && (new_mid < w1_mid_ff) &&
                               (new_mid < w1_cur_ff)));
      big1   = (new_mid > thr_pos) || (new_mid < thr_neg);
   end

   always_comb begin
      valid0_in           = s1.valid && s1.judge_prev && big0 && (above0 || below0);
      res0_in.scale_index = SCALE_INDEX_W'(s1_row);
      res0_in.time_index  = TIME_INDEX_W'(s1_col - COL_W'(1));
      res0_in.is_maximum  = above0;
      valid1_in           = s1.valid && s1.judge_last && big1 && (above1 || below1);
      res1_in.scale_index = SCALE_INDEX_W'(s1_row);
      res1_in.time_index  = TIME_INDEX_W'(s1_col);
      res1_in.is_maximum  = above1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
      end else begin
         valid0_ff <= valid0_in;
         valid1_ff <= valid1_in;
      end
   end

   always_ff @(posedge clock) begin
      res0_ff <= res0_in;
      res1_ff <= res1_in;
   end

   assign pair = '{v0: valid0_ff, r0: res0_ff, v1: valid1_ff, r1: res1_ff};

endmodule

@@ rtl/core/dogx_rsp_fifo.sv @@
module dogx_rsp_fifo
   import dogx_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dogx_pair_type        push,
   output logic [OUT_CNT_W-1:0] count,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dogx_entry_type       rsp_entry
);

   dogx_entry_type         fifo_mem_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_W-1:0]   count_ff, count_in;
   logic [OUT_CNT_W-1:0]   n_push;
   logic                   pop;
   dogx_entry_type         first, second;

   // Pack the valid slots in order; last word flags the end of the run
   always_comb begin
      n_push = OUT_CNT_W'(push.v0) + OUT_CNT_W'(push.v1);
      first  = push.v0 ? '{res: push.r0, last_of_run: !push.v1}
                       : '{res: push.r1, last_of_run: 1'b1};
      second = '{res: push.r1, last_of_run: 1'b1};
      pop    = (count_ff != '0) && rsp_ready;
      wr_ptr_in = OUT_PTR_W'(wr_ptr_ff + OUT_PTR_W'(n_push));
      rd_ptr_in = pop ? OUT_PTR_W'(rd_ptr_ff + OUT_PTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff + n_push - (pop ? OUT_CNT_W'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != '0) begin
         fifo_mem_ff[wr_ptr_ff] <= first;
      end
      if (n_push == OUT_CNT_W'(MAX_RESULTS)) begin
         fifo_mem_ff[OUT_PTR_W'(wr_ptr_ff + OUT_PTR_W'(1))] <= second;
      end
   end

   assign count     = count_ff;
   assign rsp_valid = (count_ff != '0);
   assign rsp_entry = fifo_mem_ff[rd_ptr_ff];

   // Credit check upstream must keep the queue from overflowing
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (CREDIT_W'(count_ff) + CREDIT_W'(n_push)) <= CREDIT_W'(OUT_DEPTH))
      else $error("response queue overflow");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      OUT_PTR_W'(wr_ptr_ff - rd_ptr_ff) == OUT_PTR_W'(count_ff))
      else $error("queue pointers disagree with fill count");

endmodule

@@ rtl/core/dog_extremum_detector_core.sv @@
// Difference-of-Gaussian extremum detector, one scale row after another.
// req_ channel: one signed Q16.16 sample word per handshake, raster order
// (scale row, then time within the row). rsp_ channel: one detected point
// per word (scale row, time position, max/min flag, last-of-run flag); a
// sample that closes a row can produce two words, last_of_run marks the
// final word caused by a sample. csr_ channel writes threshold, row length
// and scale count; it is always ready. The user must see that it is written
// only while the block idles; the block does not enforce it. Throughput:
// one sample per cycle while the result queue has room and no refill runs.
// Three line stores share one memory with one write and two read ports:
// each sample writes its own column and reads the two previous rows at
// that column, earlier columns come from a window. After a row length write
// that shrinks the current row, the first sample waits while the window is
// reloaded from the memory. Reset clears the counters and loads register
// defaults; line stores are not cleared. Results sit in an 8-word queue;
// req_ready drops while the queue might not hold the words of samples in
// flight, so a stalled receiver backs up input.
module dog_extremum_detector_core
   import dogx_pkg::*;
#(
   parameter int MAX_LEN    = DEF_MAX_LEN,
   parameter int MAX_SCALES = DEF_MAX_SCALES
)(
   input  logic                       clock,
   input  logic                       reset,
   // sample input
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_value,
   // result output
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [SCALE_INDEX_W-1:0]   rsp_scale_index,
   output logic [TIME_INDEX_W-1:0]    rsp_time_index,
   output logic                       rsp_is_maximum,
   output logic                       rsp_last_of_run,
   // register writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int COL_W     = $clog2(MAX_LEN);
   localparam int LEN_W     = $clog2(MAX_LEN + 1);
   localparam int RL_W      = (LEN_W > ROW_LENGTH_W) ? LEN_W : ROW_LENGTH_W;
   localparam int ROW_W     = $clog2(MAX_SCALES);
   localparam int SC_W      = $clog2(MAX_SCALES + 1);
   localparam int SCC_W     = (SC_W > SCALE_COUNT_W) ? SC_W : SCALE_COUNT_W;
   localparam int MEM_DEPTH = 3 * MAX_LEN;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   function automatic logic [1:0] line_before(input logic [1:0] line);
      return (line == 2'd0) ? 2'd2 : line - 2'd1;
   endfunction

   function automatic logic [ADDR_W-1:0] line_addr(input logic [1:0] line,
                                                   input logic [COL_W-1:0] col);
      logic [ADDR_W-1:0] base;
      case (line)
         2'd0:    base = '0;
         2'd1:    base = ADDR_W'(MAX_LEN);
         default: base = ADDR_W'(2 * MAX_LEN);
      endcase
      return base + ADDR_W'(col);
   endfunction

   // Registers and counters
   logic [THRESHOLD_W-1:0]   threshold_ff;
   logic [ROW_LENGTH_W-1:0]  row_length_ff;
   logic [SCALE_COUNT_W-1:0] scale_count_ff;
   logic [COL_W-1:0]         col_cnt_ff, col_cnt_in;
   logic [ROW_W-1:0]         row_cnt_ff, row_cnt_in;
   logic [1:0]               rot_ff, rot_in;
   logic                     fill_done_ff;
   dogx_fill_type            fill_state_ff, fill_state_in;

   // Word position
   logic [RL_W-1:0]  rl_ext;
   logic [LEN_W-1:0] len_eff;
   logic [COL_W-1:0] last_col, cur_col, col_m1, col_m2;
   logic [SCC_W-1:0] sc_ext;
   logic [SC_W-1:0]  sc_eff;
   logic [ROW_W-1:0] last_row, cur_row;
   logic             col_clamp, at_last, interior, has_l1, has_l2, stale;
   logic [1:0]       line_cur, line_mid, line_old;
   logic             accept, csr_write, credit_ok;

   // Memory ports
   logic [ADDR_W-1:0]   wr_addr, rd_addr_a, rd_addr_b;
   logic [SAMPLE_W-1:0] rd_data_a, rd_data_b;

   // Compare stage
   dogx_s1_type                s1_ff;
   logic [COL_W-1:0]           s1_col_ff;
   logic [ROW_W-1:0]           s1_row_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   dogx_pair_type              pair;
   logic [OUT_CNT_W-1:0]       fifo_count;
   dogx_entry_type             rsp_entry;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign accept    = req_valid && req_ready;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= THRESHOLD_RST;
         row_length_ff  <= ROW_LENGTH_RST;
         scale_count_ff <= SCALE_COUNT_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_THRESHOLD:   threshold_ff   <= csr_wdata[THRESHOLD_W-1:0];
            CSR_ROW_LENGTH:  row_length_ff  <= csr_wdata[ROW_LENGTH_W-1:0];
            CSR_SCALE_COUNT: scale_count_ff <= csr_wdata[SCALE_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective row length (1..MAX_LEN) and scale count (1..MAX_SCALES)
   always_comb begin
      rl_ext = RL_W'(row_length_ff);
      if (rl_ext == '0) begin
         len_eff = LEN_W'(1);
      end else if (rl_ext > RL_W'(MAX_LEN)) begin
         len_eff = LEN_W'(MAX_LEN);
      end else begin
         len_eff = LEN_W'(rl_ext);
      end
      sc_ext = SCC_W'(scale_count_ff);
      if (sc_ext == '0) begin
         sc_eff = SC_W'(1);
      end else if (sc_ext > SCC_W'(MAX_SCALES)) begin
         sc_eff = SC_W'(MAX_SCALES);
      end else begin
         sc_eff = SC_W'(sc_ext);
      end
   end

   // Position of the incoming word
   always_comb begin
      last_col  = COL_W'(len_eff - LEN_W'(1));
      last_row  = ROW_W'(sc_eff - SC_W'(1));
      col_clamp = LEN_W'(col_cnt_ff) >= len_eff;
      cur_col   = col_clamp ? last_col : col_cnt_ff;
      cur_row   = (SC_W'(row_cnt_ff) >= sc_eff) ? last_row : row_cnt_ff;
      at_last   = (cur_col == last_col);
      interior  = (cur_row >= ROW_W'(2));
      has_l1    = (cur_col != '0);
      has_l2    = (LEN_W'(cur_col) >= LEN_W'(2));
      col_m1    = cur_col - COL_W'(1);
      col_m2    = has_l2 ? COL_W'(LEN_W'(cur_col) - LEN_W'(2)) : '0;
      line_cur  = rot_ff;
      line_mid  = line_before(rot_ff);
      line_old  = line_before(line_mid);
      // a shrunken row jumps the column back: window no longer matches
      stale     = col_clamp && has_l1 && !fill_done_ff;
   end

   // Room for the results of every word in flight plus this one
   assign credit_ok = (CREDIT_W'(fifo_count) + CREDIT_W'(pair.v0) + CREDIT_W'(pair.v1) +
                       (s1_ff.valid ? CREDIT_W'(MAX_RESULTS) : '0) +
                       CREDIT_W'(MAX_RESULTS)) <= CREDIT_W'(OUT_DEPTH);

   // Counter advance
   always_comb begin
      if (at_last) begin
         col_cnt_in = '0;
         rot_in     = (rot_ff == 2'd2) ? 2'd0 : rot_ff + 2'd1;
         row_cnt_in = (cur_row == last_row) ? '0 : cur_row + ROW_W'(1);
      end else begin
         col_cnt_in = cur_col + COL_W'(1);
         rot_in     = rot_ff;
         row_cnt_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         rot_ff     <= '0;
      end else if (accept) begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
         rot_ff     <= rot_in;
      end
   end

   // Refill sequencer: next state
   always_comb begin
      fill_state_in = fill_state_ff;
      case (fill_state_ff)
         FILL_IDLE: begin
            if (req_valid && stale && !s1_ff.valid) begin
               fill_state_in = FILL_RD0;
            end
         end
         FILL_RD0: fill_state_in = FILL_RD1;
         FILL_RD1: fill_state_in = FILL_RD2;
         FILL_RD2: fill_state_in = FILL_CAP;
         FILL_CAP: fill_state_in = FILL_IDLE;
         default:  fill_state_in = FILL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_state_ff <= FILL_IDLE;
         fill_done_ff  <= 1'b0;
      end else begin
         fill_state_ff <= fill_state_in;
         if (accept || csr_write) begin
            fill_done_ff <= 1'b0;
         end else if (fill_state_ff == FILL_CAP) begin
            fill_done_ff <= 1'b1;
         end
      end
   end

   // Refill sequencer: outputs (read addresses and input gating)
   always_comb begin
      rd_addr_a = line_addr(line_mid, cur_col);
      rd_addr_b = line_addr(line_old, cur_col);
      req_ready = credit_ok && !stale && (fill_state_ff == FILL_IDLE);
      case (fill_state_ff)
         FILL_RD0: begin
            rd_addr_a = line_addr(line_mid, col_m1);
            rd_addr_b = line_addr(line_old, col_m1);
         end
         FILL_RD1: begin
            rd_addr_a = line_addr(line_cur, col_m1);
            rd_addr_b = line_addr(line_old, col_m2);
         end
         FILL_RD2: begin
            rd_addr_a = line_addr(line_mid, col_m2);
            rd_addr_b = line_addr(line_cur, col_m2);
         end
         default: ;
      endcase
   end

   assign wr_addr = line_addr(line_cur, cur_col);

   dogx_line_store #(
      .DEPTH  (MEM_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_line_store (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (wr_addr),
      .wr_data   ($unsigned(req_sample_value)),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Compare stage, aligned with the memory read data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff.valid      <= accept;
         s1_ff.has_l1     <= has_l1;
         s1_ff.has_l2     <= has_l2;
         s1_ff.judge_prev <= interior && has_l1;
         s1_ff.judge_last <= interior && at_last;
      end
   end

   always_ff @(posedge clock) begin
      s1_col_ff    <= cur_col;
      s1_row_ff    <= cur_row - ROW_W'(1);
      s1_sample_ff <= req_sample_value;
   end

   dogx_judge #(
      .COL_W (COL_W),
      .ROW_W (ROW_W)
   ) u_judge (
      .clock      (clock),
      .reset      (reset),
      .threshold  (threshold_ff),
      .s1         (s1_ff),
      .s1_col     (s1_col_ff),
      .s1_row     (s1_row_ff),
      .s1_sample  (s1_sample_ff),
      .rd_data_a  (rd_data_a),
      .rd_data_b  (rd_data_b),
      .fill_state (fill_state_ff),
      .pair       (pair)
   );

   dogx_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (pair),
      .count     (fifo_count),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_entry (rsp_entry)
   );

   assign rsp_scale_index = rsp_entry.res.scale_index;
   assign rsp_time_index  = rsp_entry.res.time_index;
   assign rsp_is_maximum  = rsp_entry.res.is_maximum;
   assign rsp_last_of_run = rsp_entry.last_of_run;

   // No word may enter while the window is being reloaded
   a_fill_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (fill_state_ff != FILL_IDLE) |-> !req_ready)
      else $error("input taken during window refill");

   // Refill loads the window directly, so the compare stage must be empty
   a_fill_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (fill_state_ff != FILL_IDLE) |-> !s1_ff.valid)
      else $error("compare stage busy during window refill");

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      accept |-> (LEN_W'(cur_col) < len_eff) && (rot_ff != 2'd3))
      else $error("word written outside the current line");

endmodule

@@ sim/tb_dog_extremum_detector_core.sv @@
`timescale 1ns / 1ps

module tb_dog_extremum_detector_core;
   import dogx_pkg::*;

   localparam int LINE_LEN     = DEF_MAX_LEN;
   localparam int SCALE_LIMIT  = DEF_MAX_SCALES;
   localparam int RANDOM_WORDS = 900;
   localparam int SETTLE       = 10;
   localparam int PLAN_STEPS   = 34;
   localparam int REPORT_CAP   = 30;

   // index with no register behind it; writes to it change no setting
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [SCALE_INDEX_W-1:0] scale_row;
      logic [TIME_INDEX_W-1:0]  tpos;
      logic                     is_max;
      logic                     last;
   } point_t;

   localparam point_t NO_POINT = '0;

   typedef enum logic [1:0] {
      EXT_NONE,
      EXT_MIN,
      EXT_MAX
   } extremum_t;

   typedef enum logic {
      STEP_WORD,
      STEP_CSR
   } step_kind_t;

   // one row of the directed table; typed rows carry their results inline
   typedef struct packed {
      step_kind_t             kind;
      logic [CSR_INDEX_W-1:0] idx;
      logic [31:0]            data;
      logic                   typed;
      logic [1:0]             typed_n;
      point_t                 p0;
      point_t                 p1;
   } plan_step_t;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_value;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [SCALE_INDEX_W-1:0]   rsp_scale_index;
   logic [TIME_INDEX_W-1:0]    rsp_time_index;
   logic                       rsp_is_maximum;
   logic                       rsp_last_of_run;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;

   dog_extremum_detector_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_scale_index  (rsp_scale_index),
      .rsp_time_index   (rsp_time_index),
      .rsp_is_maximum   (rsp_is_maximum),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Predictor state: three line stores, counters and registers
   logic [31:0]              line_mem [0:3*LINE_LEN-1];
   int                       row_ctr;
   int                       col_ctr;
   int                       rotation;
   int                       set_min_len;
   logic [THRESHOLD_W-1:0]   thr_reg;
   logic [ROW_LENGTH_W-1:0]  len_reg;
   logic [SCALE_COUNT_W-1:0] sc_reg;

   point_t     pending_points [$];
   plan_step_t plan [PLAN_STEPS];
   int         errors;
   bit         calm;
   int         rx_left;

   always #4 clock = ~clock;

   function automatic int eff_len(input logic [ROW_LENGTH_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > LINE_LEN) return LINE_LEN;
      return int'(raw);
   endfunction

   function automatic int prev_line(input int line);
      return (line == 0) ? 2 : line - 1;
   endfunction

   // Strict min/max and threshold test of one column of the middle row
   function automatic extremum_t classify_column(input int col, input int len, input int mid);
      int     lo;
      int     hi;
      int     lines [3];
      longint v;
      longint w;
      longint t;
      bit     below_all;
      bit     above_all;
      lo = (col == 0) ? 0 : col - 1;
      hi = (col + 1 >= len) ? len - 1 : col + 1;
      v = $signed(line_mem[mid*LINE_LEN + col]);
      t = thr_reg;
      below_all = 1'b1;
      above_all = 1'b1;
      lines[0] = prev_line(mid);
      lines[1] = mid;
      lines[2] = rotation;
      for (int k = 0; k < 3; k++) begin
         for (int x = lo; x <= hi; x++) begin
            if (!(k == 1 && x == col)) begin
               w = $signed(line_mem[lines[k]*LINE_LEN + x]);
               if (!(v < w)) below_all = 1'b0;
               if (!(v > w)) above_all = 1'b0;
            end
         end
      end
      if (!(v > t || v < -t)) return EXT_NONE;
      if (above_all) return EXT_MAX;
      if (below_all) return EXT_MIN;
      return EXT_NONE;
   endfunction

   // Take one sample word, return the points it completes
   function automatic void detect_points(input logic [31:0] v, output int n,
                                         output point_t p0, output point_t p1);
      int        len;
      int        sc;
      int        c;
      int        r;
      int        cur;
      int        mid;
      int        ncols;
      int        cols [2];
      extremum_t kind;
      point_t    pt;
      len = eff_len(len_reg);
      sc  = (sc_reg == 0) ? 1 : (sc_reg > SCALE_LIMIT) ? SCALE_LIMIT : int'(sc_reg);
      if (row_ctr == 0 && col_ctr == 0) set_min_len = len;
      else if (len < set_min_len) set_min_len = len;
      c = (col_ctr >= len) ? len - 1 : col_ctr;
      r = (row_ctr >= sc) ? sc - 1 : row_ctr;
      if (rotation > 2) rotation = 0;
      cur = rotation;
      mid = prev_line(cur);
      line_mem[cur*LINE_LEN + c] = v;

      ncols = 0;
      if (r >= 2) begin
         if (c >= 1) begin
            cols[ncols] = c - 1;
            ncols++;
         end
         if (c == len - 1) begin
            cols[ncols] = c;
            ncols++;
         end
      end
      n  = 0;
      p0 = NO_POINT;
      p1 = NO_POINT;
      for (int i = 0; i < ncols; i++) begin
         kind = classify_column(cols[i], len, mid);
         if (kind != EXT_NONE) begin
            pt.scale_row = SCALE_INDEX_W'(r - 1);
            pt.tpos      = TIME_INDEX_W'(cols[i]);
            pt.is_max    = (kind == EXT_MAX);
            pt.last      = 1'b0;
            if (n == 0) p0 = pt;
            else p1 = pt;
            n++;
         end
      end
      if (n == 1) p0.last = 1'b1;
      if (n == 2) p1.last = 1'b1;

      // advance raster position
      if (c == len - 1) begin
         col_ctr  = 0;
         rotation = (cur == 2) ? 0 : cur + 1;
         row_ctr  = (r == sc - 1) ? 0 : r + 1;
      end else begin
         col_ctr = c + 1;
         row_ctr = r;
      end
   endfunction

   function automatic int pick_gap();
      int k;
      if (calm) return 0;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 85) return $urandom_range(1, 3);
      if (k < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   task automatic note_mismatch(input string what);
      errors++;
      if (errors <= REPORT_CAP) $display("%0t ns  mismatch: %s", $time, what);
   endtask

   // Send one sample word; predicted or typed points go on the pending list
   task automatic send_word(input logic [31:0] v, input logic typed, input logic [1:0] typed_n,
                            input point_t t0, input point_t t1);
      int     gap;
      int     n;
      point_t p0;
      point_t p1;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      detect_points(v, n, p0, p1);
      if (typed) begin
         n  = typed_n;
         p0 = t0;
         p1 = t1;
      end
      if (n > 0) pending_points.push_back(p0);
      if (n > 1) pending_points.push_back(p1);
      @(negedge clock);
   endtask

   // Stop sending, wait for every pending point, then let the pipe settle
   task automatic drain(input int settle);
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_THRESHOLD:   thr_reg = data[THRESHOLD_W-1:0];
         CSR_ROW_LENGTH: begin
            len_reg = data[ROW_LENGTH_W-1:0];
            if (!(row_ctr == 0 && col_ctr == 0) && eff_len(len_reg) < set_min_len)
               set_min_len = eff_len(len_reg);
         end
         CSR_SCALE_COUNT: sc_reg = data[SCALE_COUNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // New settings for a random phase; row length only grows at a set start
   task automatic retune();
      int          k;
      int          cap;
      int          new_len;
      int          new_sc;
      logic [31:0] data;
      cap = (row_ctr == 0 && col_ctr == 0) ? LINE_LEN : set_min_len;

      if ($urandom_range(0, 6) != 0) begin
         k = $urandom_range(0, 9);
         if (k < 3) data = 32'd0;
         else if (k < 6) data = $urandom_range(0, 32'h0003_0000);
         else if (k < 9) data = $urandom;
         else data = Q_MAX;
         data[31] = $urandom_range(0, 1);
         write_reg(CSR_THRESHOLD, data);
      end

      if ($urandom_range(0, 6) != 0) begin
         k = $urandom_range(0, 19);
         if (k < 13) new_len = $urandom_range(1, 8);
         else if (k < 16) new_len = $urandom_range(9, 40);
         else if (k == 16) new_len = 0;
         else if (k == 17) new_len = 2047;
         else if (k == 18) new_len = LINE_LEN;
         else new_len = $urandom_range(LINE_LEN + 1, 2046);
         if (eff_len(ROW_LENGTH_W'(new_len)) > cap) new_len = $urandom_range(1, cap);
         data = $urandom;
         data[ROW_LENGTH_W-1:0] = ROW_LENGTH_W'(new_len);
         write_reg(CSR_ROW_LENGTH, data);
      end

      if ($urandom_range(0, 6) != 0) begin
         k = $urandom_range(0, 19);
         if (k < 12) new_sc = $urandom_range(3, 6);
         else if (k < 15) new_sc = k - 12;
         else if (k < 17) new_sc = SCALE_LIMIT;
         else if (k == 17) new_sc = 127;
         else new_sc = $urandom_range(7, 126);
         data = $urandom;
         data[SCALE_COUNT_W-1:0] = SCALE_COUNT_W'(new_sc);
         write_reg(CSR_SCALE_COUNT, data);
      end

      if ($urandom_range(0, 9) == 0) write_reg(CSR_SPARE, $urandom);
   endtask

   function automatic logic [31:0] pick_sample();
      int k;
      k = $urandom_range(0, 9);
      if (k < 4) return $urandom;
      // small whole values: many ties and threshold crossings
      if (k < 8) return (int'($urandom_range(0, 8)) - 4) * 32'sh0001_0000;
      case ($urandom_range(0, 4))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return 32'hFFFF_FFFF;
         3: return 32'd1;
         default: return 32'd0;
      endcase
   endfunction

   // Receiver: runs of ready and stall of random length
   always @(negedge clock) begin
      if (calm) begin
         rsp_ready <= 1'b1;
      end else if (rx_left != 0) begin
         rx_left <= rx_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 2) != 0);
         rx_left   <= pick_gap();
      end
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            note_mismatch($sformatf("result word (%0d,%0d) with nothing pending",
                                    rsp_scale_index, rsp_time_index));
         end else begin
            if (rsp_scale_index !== pending_points[0].scale_row)
               note_mismatch($sformatf("scale_index %0d, wanted %0d",
                                       rsp_scale_index, pending_points[0].scale_row));
            if (rsp_time_index !== pending_points[0].tpos)
               note_mismatch($sformatf("time_index %0d, wanted %0d",
                                       rsp_time_index, pending_points[0].tpos));
            if (rsp_is_maximum !== pending_points[0].is_max)
               note_mismatch($sformatf("is_maximum %0b, wanted %0b at (%0d,%0d)",
                                       rsp_is_maximum, pending_points[0].is_max,
                                       pending_points[0].scale_row, pending_points[0].tpos));
            if (rsp_last_of_run !== pending_points[0].last)
               note_mismatch($sformatf("last_of_run %0b, wanted %0b at (%0d,%0d)",
                                       rsp_last_of_run, pending_points[0].last,
                                       pending_points[0].scale_row, pending_points[0].tpos));
            pending_points.delete(0);
         end
      end
   end

   // Run limit
   initial begin
      #10ms;
      $display("FAIL dog_extremum_detector_core");
      $finish;
   end

   initial begin : stimulus
      int words_sent;
      int phase_words;

      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_value = '0;
      rsp_ready        = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = CSR_THRESHOLD;
      csr_wdata        = '0;
      errors           = 0;
      calm             = 1'b0;
      rx_left          = 0;
      row_ctr          = 0;
      col_ctr          = 0;
      rotation         = 0;
      set_min_len      = LINE_LEN;
      thr_reg          = THRESHOLD_RST;
      len_reg          = ROW_LENGTH_RST;
      sc_reg           = SCALE_COUNT_RST;
      for (int i = 0; i < 3*LINE_LEN; i++) line_mem[i] = '0;

      // Directed table. Row 0 starts at reset sizes, then shrinks to 3
      // under a running column counter. A max, a min and a max at the row end
      // (two words from one sample), then the same field at full threshold
      // where only the most negative value passes, then too few rows, then
      // single-column rows checked against the predictor.
      plan = '{
         '{STEP_WORD, '0, 32'd0, 1'b1, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, 32'd0, 1'b1, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, 32'd0, 1'b1, 2'd0, NO_POINT, NO_POINT},
         '{STEP_CSR, CSR_ROW_LENGTH, 32'd3, 1'b0, 2'd0, NO_POINT, NO_POINT},
         '{STEP_CSR, CSR_SCALE_COUNT, 32'd3, 1'b0, 2'd0, NO_POINT, NO_POINT},
         '{STEP_CSR, CSR_THRESHOLD, 32'd0, 1'b0, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, 32'd0, 1'b1, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, Q_MAX, 1'b1, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, Q_MIN, 1'b1, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, 32'd1, 1'b1, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, 32'd0, 1'b1, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, 32'd0, 1'b1, 2'd1, point_t'{6'd1, 10'd0, 1'b1, 1'b1}, NO_POINT},
         '{STEP_WORD, '0, 32'd0, 1'b1, 2'd2, point_t'{6'd1, 10'd1, 1'b0, 1'b0},
           point_t'{6'd1, 10'd2, 1'b1, 1'b1}},
         '{STEP_CSR, CSR_THRESHOLD, 32'hFFFF_FFFF, 1'b0, 2'd0, NO_POINT, NO_POINT},
         '{STEP_CSR, CSR_SPARE, 32'h1234_5678, 1'b0, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, 32'd0, 1'b1, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, 32'd0, 1'b1, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, 32'd0, 1'b1, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, Q_MAX, 1'b1, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, Q_MIN, 1'b1, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, 32'd1, 1'b1, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, 32'd0, 1'b1, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, 32'd0, 1'b1, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, 32'd0, 1'b1, 2'd1, point_t'{6'd1, 10'd1, 1'b0, 1'b1}, NO_POINT},
         '{STEP_CSR, CSR_THRESHOLD, 32'd0, 1'b0, 2'd0, NO_POINT, NO_POINT},
         '{STEP_CSR, CSR_ROW_LENGTH, 32'd1, 1'b0, 2'd0, NO_POINT, NO_POINT},
         '{STEP_CSR, CSR_SCALE_COUNT, 32'd2, 1'b0, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, Q_MAX, 1'b1, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, Q_MIN, 1'b1, 2'd0, NO_POINT, NO_POINT},
         '{STEP_CSR, CSR_SCALE_COUNT, 32'd4, 1'b0, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, 32'h0005_0000, 1'b0, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, 32'hFFFD_0000, 1'b0, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, 32'h0009_0000, 1'b0, 2'd0, NO_POINT, NO_POINT},
         '{STEP_WORD, '0, 32'h0002_0000, 1'b0, 2'd0, NO_POINT, NO_POINT}
      };

      // synchronous reset, released on a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part
      for (int i = 0; i < PLAN_STEPS; i++) begin
         if (plan[i].kind == STEP_CSR) begin
            drain(SETTLE);
            write_reg(plan[i].idx, plan[i].data);
         end else begin
            send_word(plan[i].data, plan[i].typed, plan[i].typed_n, plan[i].p0, plan[i].p1);
         end
      end

      // random phases, each under new settings
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         drain(SETTLE);
         retune();
         calm = ($urandom_range(0, 4) == 0);
         phase_words = $urandom_range(20, 90);
         for (int i = 0; i < phase_words; i++) begin
            // now and then hold off until every pending point is out
            if ($urandom_range(0, 59) == 0) drain(0);
            send_word(pick_sample(), 1'b0, 2'd0, NO_POINT, NO_POINT);
         end
         words_sent += phase_words;
      end

      calm = 1'b0;
      drain(20);
      if (errors == 0) begin
         $display("PASS dog_extremum_detector_core");
      end else begin
         $display("FAIL dog_extremum_detector_core");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/dogx_pkg.sv
rtl/core/dogx_line_store.sv
rtl/core/dogx_judge.sv
rtl/core/dogx_rsp_fifo.sv
rtl/core/dog_extremum_detector_core.sv
sim/tb_dog_extremum_detector_core.sv
